>>> rtl/core/rkc_pkg.sv
// Package for the range keyed second chance cache.
// Holds the controller state type, the command and status structs and field widths.
// Depends on nothing.
`default_nettype none

package rkc_pkg;

  localparam int WORKER_W = 3;
  localparam int DATA_W   = 64;
  localparam int SLOT_W   = 3;
  // One stored entry: second-chance bit, handle, range end, range start.
  localparam int ENTRY_W  = 3 * DATA_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PICK,
    ST_SWEEP
  } rkc_state_t;

  typedef struct packed {
    logic capture;
    logic emit_oor;
    logic load_row;
    logic resolve;
    logic probe;
  } rkc_cmd_t;

  typedef struct packed {
    logic oor;
    logic any_hit;
    logic probe_set;
  } rkc_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/rkc_ctrl.sv
// Controller state machine of the range keyed second chance cache.
// Drives datapath commands from start and datapath status; uses rkc_pkg.
`default_nettype none

module rkc_ctrl
  import rkc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire rkc_stat_t stat,
  output rkc_cmd_t       cmd,
  output logic           busy
);

  rkc_state_t state_r;
  rkc_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
        if (start) begin
          if (stat.oor) begin
            cmd.emit_oor = 1'b1;
          end else begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cmd.load_row = 1'b1;
        state_nxt    = ST_PICK;
      end
      ST_PICK: begin
        cmd.resolve = 1'b1;
        state_nxt   = stat.any_hit ? ST_IDLE : ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd.probe = 1'b1;
        if (!stat.probe_set) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // A lookup is entered only from an accepted beat, and resolution follows the row load.
  a_load_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOAD |-> $past(state_r == ST_IDLE && start && !stat.oor))
    else $error("row load entered without an accepted beat");

  a_pick_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PICK |-> $past(state_r == ST_LOAD))
    else $error("hit resolution not preceded by a row load");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.load_row, cmd.resolve, cmd.probe}))
    else $error("more than one datapath phase commanded");

endmodule

`default_nettype wire

>>> rtl/core/rkc_datapath.sv
// Datapath of the range keyed second chance cache: partition row memory,
// parallel range compare, clock hands, sweep and result registers. Uses rkc_pkg.
`default_nettype none

module rkc_datapath
  import rkc_pkg::*;
#(
  parameter int ENTRIES = 8,
  parameter int WORKERS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rkc_cmd_t            cmd,
  output rkc_stat_t                stat,
  input  wire logic [WORKER_W-1:0] in_worker,
  input  wire logic [DATA_W-1:0]   in_stamp,
  input  wire logic [DATA_W-1:0]   in_fill_start,
  input  wire logic [DATA_W-1:0]   in_fill_end,
  input  wire logic [DATA_W-1:0]   in_fill_handle,
  output logic                     out_strobe,
  output logic                     out_hit,
  output logic [SLOT_W-1:0]        out_slot,
  output logic [DATA_W-1:0]        out_handle
);

  localparam int MAX_W  = 2 ** WORKER_W;
  localparam int NW     = (WORKERS < MAX_W) ? WORKERS : MAX_W;
  localparam int AW     = (NW > 1) ? $clog2(NW) : 1;
  localparam int IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ROW_W  = ENTRIES * ENTRY_W;

  logic [ROW_W-1:0]    row_mem_r [NW];
  logic [NW-1:0]       row_vld_r;
  logic [IW-1:0]       hands_r [NW];

  logic [WORKER_W-1:0] worker_r;
  logic [DATA_W-1:0]   stamp_r;
  logic [DATA_W-1:0]   fill_start_r;
  logic [DATA_W-1:0]   fill_end_r;
  logic [DATA_W-1:0]   fill_handle_r;
  logic [ROW_W-1:0]    rd_q_r;
  logic                rd_vld_r;

  logic [DATA_W-1:0]   lo_r [ENTRIES];
  logic [DATA_W-1:0]   hi_r [ENTRIES];
  logic [DATA_W-1:0]   hd_r [ENTRIES];
  logic [ENTRIES-1:0]  ch_r;
  logic [ENTRIES-1:0]  hv_r;
  logic [IW-1:0]       hand_r;

  logic                out_strobe_r;
  logic                out_hit_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [DATA_W-1:0]   out_handle_r;

  logic [DATA_W-1:0]   rd_lo [ENTRIES];
  logic [DATA_W-1:0]   rd_hi [ENTRIES];
  logic [DATA_W-1:0]   rd_hd [ENTRIES];
  logic [ENTRIES-1:0]  rd_ch;
  logic [AW-1:0]       in_addr;
  logic [AW-1:0]       waddr;
  logic [IW-1:0]       hit_idx;
  logic [IW-1:0]       wr_idx;
  logic [IW-1:0]       hand_nxt;
  logic [ROW_W-1:0]    row_wdata;
  logic                any_hit;
  logic                probe_set;
  logic                wr_en;

  assign in_addr   = in_worker[AW-1:0];
  assign waddr     = worker_r[AW-1:0];
  assign any_hit   = |hv_r;
  assign probe_set = ch_r[hand_r];
  assign hand_nxt  = (hand_r == IW'(ENTRIES - 1)) ? '0 : hand_r + 1'b1;
  assign wr_idx    = cmd.probe ? hand_r : hit_idx;
  assign wr_en     = (cmd.resolve && any_hit) || (cmd.probe && !probe_set);

  assign stat.oor       = 32'(in_worker) >= WORKERS;
  assign stat.any_hit   = any_hit;
  assign stat.probe_set = probe_set;

  always_comb begin
    for (int e = 0; e < ENTRIES; e++) begin
      rd_lo[e] = rd_vld_r ? rd_q_r[e*ENTRY_W +: DATA_W] : '0;
      rd_hi[e] = rd_vld_r ? rd_q_r[e*ENTRY_W + DATA_W +: DATA_W] : '0;
      rd_hd[e] = rd_vld_r ? rd_q_r[e*ENTRY_W + 2*DATA_W +: DATA_W] : '0;
      rd_ch[e] = rd_vld_r & rd_q_r[e*ENTRY_W + 3*DATA_W];
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int e = ENTRIES - 1; e >= 0; e--) begin
      if (hv_r[e]) begin
        hit_idx = IW'(e);
      end
    end
  end

  always_comb begin
    for (int e = 0; e < ENTRIES; e++) begin
      if (IW'(e) == wr_idx) begin
        if (cmd.probe) begin
          row_wdata[e*ENTRY_W +: ENTRY_W] = {1'b1, fill_handle_r, fill_end_r, fill_start_r};
        end else begin
          row_wdata[e*ENTRY_W +: ENTRY_W] = {1'b1, hd_r[e], hi_r[e], lo_r[e]};
        end
      end else begin
        row_wdata[e*ENTRY_W +: ENTRY_W] = {ch_r[e], hd_r[e], hi_r[e], lo_r[e]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture && !stat.oor) begin
      rd_q_r <= row_mem_r[in_addr];
    end
    if (wr_en) begin
      row_mem_r[waddr] <= row_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      for (int w = 0; w < NW; w++) begin
        hands_r[w] <= '0;
      end
    end else begin
      if (wr_en) begin
        row_vld_r[waddr] <= 1'b1;
      end
      if (cmd.probe && !probe_set) begin
        hands_r[waddr] <= hand_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      worker_r      <= in_worker;
      stamp_r       <= in_stamp;
      fill_start_r  <= in_fill_start;
      fill_end_r    <= in_fill_end;
      fill_handle_r <= in_fill_handle;
      if (!stat.oor) begin
        rd_vld_r <= row_vld_r[in_addr];
      end
    end
    if (cmd.load_row) begin
      for (int e = 0; e < ENTRIES; e++) begin
        lo_r[e] <= rd_lo[e];
        hi_r[e] <= rd_hi[e];
        hd_r[e] <= rd_hd[e];
        hv_r[e] <= (rd_lo[e] <= stamp_r) && (stamp_r < rd_hi[e]);
      end
      ch_r   <= rd_ch;
      hand_r <= hands_r[waddr];
    end
    if (cmd.probe && probe_set) begin
      ch_r[hand_r] <= 1'b0;
      hand_r       <= hand_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit_oor || wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_oor) begin
      out_hit_r    <= 1'b0;
      out_slot_r   <= '0;
      out_handle_r <= '0;
    end else if (cmd.resolve && any_hit) begin
      out_hit_r    <= 1'b1;
      out_slot_r   <= SLOT_W'(hit_idx);
      out_handle_r <= hd_r[hit_idx];
    end else if (cmd.probe && !probe_set) begin
      out_hit_r    <= 1'b0;
      out_slot_r   <= SLOT_W'(hand_r);
      out_handle_r <= fill_handle_r;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_hit    = out_hit_r;
  assign out_slot   = out_slot_r;
  assign out_handle = out_handle_r;

  // A result beat follows exactly one resolving step of the previous cycle.
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(cmd.emit_oor || (cmd.resolve && any_hit)
                           || (cmd.probe && !probe_set)))
    else $error("result beat without a resolving step");

  // A written partition row reads back as valid from then on.
  a_row_valid_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> row_vld_r[waddr])
    else $error("partition row not marked valid after write");

endmodule

`default_nettype wire

>>> rtl/core/range_keyed_second_chance_cache.sv
// Top level of the range keyed second chance cache.
// Instantiates rkc_ctrl and rkc_datapath; uses rkc_pkg.
//
//   Channel  | Ports                                         | Beat taken when
//   ---------+-----------------------------------------------+------------------------
//   input    | in_worker in_stamp in_fill_start/end/handle   | start high, busy low
//   result   | out_hit out_slot out_handle                   | out_strobe high
//
// A hit goes from one accepted beat to the next through row read, parallel
// range compare, then resolve and write back. A miss adds a clock hand sweep
// of k (1 to ENTRIES + 1) probes, one entry per cycle. A worker number outside
// the partitions is answered in the next cycle, with no row read. Reset is
// synchronous and needs no clearing pass: a valid bit per partition row makes
// an unwritten row read as empty. The result strobe lasts one cycle.
`default_nettype none

module range_keyed_second_chance_cache
  import rkc_pkg::*;
#(
  parameter int ENTRIES = 8,
  parameter int WORKERS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [WORKER_W-1:0] in_worker,
  input  wire logic [DATA_W-1:0]   in_stamp,
  input  wire logic [DATA_W-1:0]   in_fill_start,
  input  wire logic [DATA_W-1:0]   in_fill_end,
  input  wire logic [DATA_W-1:0]   in_fill_handle,
  output logic                     out_strobe,
  output logic                     out_hit,
  output logic [SLOT_W-1:0]        out_slot,
  output logic [DATA_W-1:0]        out_handle
);

  rkc_cmd_t  cmd;
  rkc_stat_t stat;

  rkc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  rkc_datapath #(
    .ENTRIES (ENTRIES),
    .WORKERS (WORKERS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_worker      (in_worker),
    .in_stamp       (in_stamp),
    .in_fill_start  (in_fill_start),
    .in_fill_end    (in_fill_end),
    .in_fill_handle (in_fill_handle),
    .out_strobe     (out_strobe),
    .out_hit        (out_hit),
    .out_slot       (out_slot),
    .out_handle     (out_handle)
  );

endmodule

`default_nettype wire
